// ===== rtl/core/lpcce_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcce_pkg
// Shared types and fixed-point constants of the lpc coefficient estimator.
// ----------------------------------------------------------------------------
package lpcce_pkg;

   localparam int QBITS       = 24;   // fraction bits of the solve
   localparam int R_W         = 26;   // normalized lag, reflection, error
   localparam int COEF_W      = 40;   // coefficient in the solve, +-2^38
   localparam int ACC_W       = 64;   // numerator accumulator, +-2^62
   localparam int PROD_W      = 66;   // full coefficient by lag product
   localparam int MUL_LO_W    = 20;   // low slice of the split multiply
   localparam int DIV_STEPS   = 25;   // quotient bits of the divider
   localparam int DIV_W       = 50;   // divider remainder
   localparam int ORDER_W     = 5;
   localparam int INDEX_W     = 4;
   localparam int OUT_W       = 32;
   localparam int OUT_SHIFT   = 4;    // solve format to output format
   localparam logic [ORDER_W-1:0] ORDER_RESET = 5'd10;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CHECK,
      ST_NORM,
      ST_RWRITE,
      ST_ITER,
      ST_ACC_INIT,
      ST_N_RD,
      ST_N_MUL,
      ST_N_PROD,
      ST_N_ACC,
      ST_DIV_START,
      ST_DIV_STEP,
      ST_DIV_END,
      ST_U_RD,
      ST_U_MUL,
      ST_U_PROD,
      ST_U_WR,
      ST_C_RD,
      ST_C_WR,
      ST_K_WR,
      ST_E_MUL1,
      ST_E_PROD1,
      ST_E_K2,
      ST_E_MUL2,
      ST_E_PROD2,
      ST_E_ERR,
      ST_O_RD,
      ST_O_LOAD,
      ST_O_WAIT
   } state_type;

   typedef enum logic [1:0] {
      MUL_AR,   // coefficient by lag
      MUL_KA,   // coefficient by reflection
      MUL_KK,   // reflection squared
      MUL_EK    // error by squared reflection
   } mul_sel_type;

   typedef enum logic [1:0] {
      WD_ZERO,
      WD_UPD,
      WD_COPY,
      WD_K
   } wd_sel_type;

   typedef struct packed {
      logic        accum;
      logic        clear;
      logic        norm_load;
      logic        norm_step;
      logic        err_init;
      logic        r_we;
      logic        a_we;
      logic        acc_init;
      logic        acc_sub;
      logic        div_start;
      logic        div_step;
      logic        k_load;
      logic        k2_load;
      logic        err_upd;
      logic        rsp_load;
      logic        sing;
      mul_sel_type mul_sel;
      wd_sel_type  wd_sel;
   } cmd_type;

   typedef struct packed {
      logic energy_zero;
      logic norm_done;
      logic err_zero;
   } status_type;

endpackage

// ===== rtl/core/lpcce_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcce_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module lpcce_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/lpcce_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcce_dpath
// Lag sum accumulation, normalization, shared split multiplier, serial
// divider and coefficient storage for the levinson-durbin solve.
// ----------------------------------------------------------------------------
module lpcce_dpath #(
   parameter int MAX_ORDER    = 16,
   parameter int MAX_FRAME    = 1024,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  lpcce_pkg::cmd_type                     cmd,
   output lpcce_pkg::status_type                  status,
   input  logic signed [SAMPLE_WIDTH-1:0]         sample,
   input  logic [$clog2(MAX_ORDER+1)-1:0]         r_index,
   input  logic [$clog2(MAX_ORDER+1)-1:0]         r_raddr,
   input  logic [$clog2(2*MAX_ORDER)-1:0]         a_raddr,
   input  logic [$clog2(2*MAX_ORDER)-1:0]         a_waddr,
   output logic signed [lpcce_pkg::OUT_W-1:0]     coefficient
);
   import lpcce_pkg::*;

   localparam int LAG_W = 2 * SAMPLE_WIDTH + $clog2(MAX_FRAME) + 1;
   localparam int NV_W  = (LAG_W > R_W) ? LAG_W : R_W;
   localparam int SH_W  = $clog2(NV_W + 1);
   localparam int EXT_W = LAG_W + QBITS;
   localparam int CNT_W = $clog2(MAX_FRAME + 1);
   localparam int PP_W  = 2 * SAMPLE_WIDTH;
   localparam int HI_W  = COEF_W - MUL_LO_W;
   localparam int SUM_W = PROD_W + 1;
   localparam int U_W   = PROD_W - QBITS + 1;

   localparam logic [NV_W-1:0] V_HI = NV_W'(1) << QBITS;
   localparam logic [NV_W-1:0] V_LO = NV_W'(1) << (QBITS - 1);
   localparam logic signed [EXT_W-1:0] R_MAX = EXT_W'(1) << QBITS;
   localparam logic signed [EXT_W-1:0] R_MIN = -R_MAX;
   localparam logic signed [SUM_W-1:0] ACC_MAX = SUM_W'(1) << 62;
   localparam logic signed [SUM_W-1:0] ACC_MIN = -ACC_MAX;
   localparam logic signed [U_W-1:0] COEF_MAX = U_W'(1) << 38;
   localparam logic signed [U_W-1:0] COEF_MIN = -COEF_MAX;
   localparam logic [DIV_STEPS-1:0] Q_MAX = DIV_STEPS'(1) << QBITS;
   localparam logic signed [COEF_W-1:0] OUT_MAX = (COEF_W'(1) << (OUT_W - 1)) - 1;
   localparam logic signed [COEF_W-1:0] OUT_MIN = -OUT_MAX - 1;

   // frame accumulation
   logic signed [SAMPLE_WIDTH-1:0] delay_ff [MAX_ORDER];
   logic signed [LAG_W-1:0]        lag_ff   [MAX_ORDER+1];
   logic [CNT_W-1:0]               count_ff;
   logic signed [PP_W-1:0]         lag_prod [MAX_ORDER+1];

   always_comb begin
      lag_prod[0] = sample * sample;
      for (int k = 1; k <= MAX_ORDER; k++) begin
         lag_prod[k] = sample * delay_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int k = 0; k < MAX_ORDER; k++) begin
            delay_ff[k] <= '0;
         end
         for (int k = 0; k <= MAX_ORDER; k++) begin
            lag_ff[k] <= '0;
         end
         count_ff <= '0;
      end else if (cmd.accum && (count_ff < CNT_W'(MAX_FRAME))) begin
         for (int k = 0; k <= MAX_ORDER; k++) begin
            lag_ff[k] <= lag_ff[k] + LAG_W'(lag_prod[k]);
         end
         for (int k = MAX_ORDER - 1; k > 0; k--) begin
            delay_ff[k] <= delay_ff[k-1];
         end
         delay_ff[0] <= sample;
         count_ff    <= count_ff + CNT_W'(1);
      end
   end

   // normalization search
   logic [NV_W-1:0] v_ff;
   logic [SH_W-1:0] down_ff;
   logic [SH_W-1:0] up_ff;

   always_ff @(posedge clock) begin
      if (cmd.norm_load) begin
         v_ff    <= NV_W'(lag_ff[0]);
         down_ff <= '0;
         up_ff   <= '0;
      end else if (cmd.norm_step) begin
         if (v_ff >= V_HI) begin
            v_ff    <= v_ff >> 1;
            down_ff <= down_ff + SH_W'(1);
         end else begin
            v_ff  <= v_ff << 1;
            up_ff <= up_ff + SH_W'(1);
         end
      end
   end

   logic signed [EXT_W-1:0] lag_ext;
   logic signed [EXT_W-1:0] lag_shift;
   logic signed [R_W-1:0]   r_norm;

   always_comb begin
      lag_ext   = EXT_W'(lag_ff[r_index]);
      lag_shift = (down_ff != '0) ? (lag_ext >>> down_ff) : (lag_ext <<< up_ff);
      if (lag_shift > R_MAX) begin
         r_norm = R_W'(R_MAX);
      end else if (lag_shift < R_MIN) begin
         r_norm = R_W'(R_MIN);
      end else begin
         r_norm = lag_shift[R_W-1:0];
      end
   end

   // storage
   logic signed [R_W-1:0]    r_q;
   logic signed [COEF_W-1:0] a_q;
   logic signed [COEF_W-1:0] a_wd;

   lpcce_ram #(.WIDTH(R_W), .DEPTH(MAX_ORDER + 1)) u_r_ram (
      .clock (clock),
      .we    (cmd.r_we),
      .waddr (r_index),
      .wdata (r_norm),
      .raddr (r_raddr),
      .rdata (r_q)
   );

   lpcce_ram #(.WIDTH(COEF_W), .DEPTH(2 * MAX_ORDER)) u_a_ram (
      .clock (clock),
      .we    (cmd.a_we),
      .waddr (a_waddr),
      .wdata (a_wd),
      .raddr (a_raddr),
      .rdata (a_q)
   );

   // split multiplier, partial products then full product
   logic signed [R_W-1:0]    k_ff;
   logic signed [R_W-1:0]    k2_ff;
   logic signed [R_W-1:0]    err_ff;
   logic signed [COEF_W-1:0] opa;
   logic signed [R_W-1:0]    opb;
   logic signed [HI_W-1:0]   opa_hi;
   logic signed [MUL_LO_W:0] opa_lo;
   logic signed [HI_W+R_W-1:0]     pp_hi_ff;
   logic signed [MUL_LO_W+R_W:0]   pp_lo_ff;
   logic signed [PROD_W-1:0]       prod_ff;
   logic signed [PROD_W-1:0]       prod_q;

   always_comb begin
      unique case (cmd.mul_sel)
         MUL_AR: begin
            opa = a_q;
            opb = r_q;
         end
         MUL_KA: begin
            opa = a_q;
            opb = k_ff;
         end
         MUL_KK: begin
            opa = COEF_W'(k_ff);
            opb = k_ff;
         end
         MUL_EK: begin
            opa = COEF_W'(k2_ff);
            opb = err_ff;
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
      opa_hi = opa[COEF_W-1:MUL_LO_W];
      opa_lo = {1'b0, opa[MUL_LO_W-1:0]};
   end

   always_ff @(posedge clock) begin
      pp_hi_ff <= opa_hi * opb;
      pp_lo_ff <= opa_lo * opb;
      prod_ff  <= (PROD_W'(pp_hi_ff) <<< MUL_LO_W) + PROD_W'(pp_lo_ff);
   end

   assign prod_q = prod_ff >>> QBITS;

   // numerator accumulation
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [SUM_W-1:0] acc_sum;

   assign acc_sum = SUM_W'(acc_ff) - SUM_W'(prod_ff);

   always_ff @(posedge clock) begin
      if (cmd.acc_init) begin
         acc_ff <= ACC_W'(r_q) <<< QBITS;
      end else if (cmd.acc_sub) begin
         if (acc_sum > ACC_MAX) begin
            acc_ff <= ACC_W'(ACC_MAX);
         end else if (acc_sum < ACC_MIN) begin
            acc_ff <= ACC_W'(ACC_MIN);
         end else begin
            acc_ff <= acc_sum[ACC_W-1:0];
         end
      end
   end

   // serial restoring divider on magnitudes
   logic [ACC_W-1:0]     acc_mag;
   logic [ACC_W-1:0]     div_lim;
   logic [DIV_W-1:0]     rem_ff;
   logic [DIV_W-1:0]     dsr_ff;
   logic [DIV_STEPS-1:0] quo_ff;
   logic                 neg_ff;
   logic                 big_ff;
   logic [DIV_STEPS-1:0] quo_sat;

   assign acc_mag = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign div_lim = ACC_W'(err_ff[R_W-2:0]) << DIV_STEPS;
   assign quo_sat = (big_ff || (quo_ff > Q_MAX)) ? Q_MAX : quo_ff;

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         neg_ff <= acc_ff[ACC_W-1];
         big_ff <= acc_mag >= div_lim;
         rem_ff <= acc_mag[DIV_W-1:0];
         dsr_ff <= DIV_W'(err_ff[R_W-2:0]) << QBITS;
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         if (rem_ff >= dsr_ff) begin
            rem_ff <= rem_ff - dsr_ff;
            quo_ff <= {quo_ff[DIV_STEPS-2:0], 1'b1};
         end else begin
            quo_ff <= {quo_ff[DIV_STEPS-2:0], 1'b0};
         end
         dsr_ff <= dsr_ff >> 1;
      end
   end

   // reflection, squared reflection and prediction error
   always_ff @(posedge clock) begin
      if (cmd.k_load) begin
         k_ff <= neg_ff ? -$signed({1'b0, quo_sat}) : $signed({1'b0, quo_sat});
      end
      if (cmd.k2_load) begin
         k2_ff <= prod_q[R_W-1:0];
      end
      if (cmd.err_init) begin
         err_ff <= v_ff[R_W-1:0];
      end else if (cmd.err_upd) begin
         err_ff <= err_ff - prod_q[R_W-1:0];
      end
   end

   // coefficient write data
   logic signed [U_W-1:0] a_upd;

   always_comb begin
      a_upd = U_W'(a_q) - $signed(prod_q[U_W-1:0]);
      unique case (cmd.wd_sel)
         WD_ZERO: a_wd = '0;
         WD_UPD: begin
            if (a_upd > COEF_MAX) begin
               a_wd = COEF_W'(COEF_MAX);
            end else if (a_upd < COEF_MIN) begin
               a_wd = COEF_W'(COEF_MIN);
            end else begin
               a_wd = a_upd[COEF_W-1:0];
            end
         end
         WD_COPY: a_wd = a_q;
         WD_K:    a_wd = COEF_W'(k_ff);
         default: a_wd = '0;
      endcase
   end

   // output conversion
   logic signed [COEF_W-1:0] a_round;
   logic signed [OUT_W-1:0]  coefficient_ff;

   assign a_round = (a_q + COEF_W'(8)) >>> OUT_SHIFT;

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         if (cmd.sing) begin
            coefficient_ff <= '0;
         end else if (a_round > OUT_MAX) begin
            coefficient_ff <= OUT_W'(OUT_MAX);
         end else if (a_round < OUT_MIN) begin
            coefficient_ff <= OUT_W'(OUT_MIN);
         end else begin
            coefficient_ff <= a_round[OUT_W-1:0];
         end
      end
   end

   assign coefficient        = coefficient_ff;
   assign status.energy_zero = (lag_ff[0] == '0);
   assign status.norm_done   = (v_ff >= V_LO) && (v_ff < V_HI);
   assign status.err_zero    = (err_ff == '0);

endmodule

// ===== rtl/core/lpcce_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcce_ctrl
// Sequencer for frame intake, normalization, levinson-durbin iterations
// and coefficient output; also holds the order register.
// ----------------------------------------------------------------------------
module lpcce_ctrl #(
   parameter int MAX_ORDER = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_frame_end,
   output logic                                req_ready,
   input  logic                                csr_valid,
   input  logic [lpcce_pkg::ORDER_W-1:0]       csr_order,
   output logic                                csr_ready,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [lpcce_pkg::INDEX_W-1:0]       rsp_coeff_index,
   output logic                                rsp_last_coeff,
   output logic                                rsp_singular,
   output lpcce_pkg::cmd_type                  cmd,
   input  lpcce_pkg::status_type               status,
   output logic [$clog2(MAX_ORDER+1)-1:0]      r_index,
   output logic [$clog2(MAX_ORDER+1)-1:0]      r_raddr,
   output logic [$clog2(2*MAX_ORDER)-1:0]      a_raddr,
   output logic [$clog2(2*MAX_ORDER)-1:0]      a_waddr
);
   import lpcce_pkg::*;

   localparam int IW   = $clog2(MAX_ORDER + 2);
   localparam int XW   = IW + 2;
   localparam int RAW  = $clog2(MAX_ORDER + 1);
   localparam int AAW  = $clog2(2 * MAX_ORDER);
   localparam int DCW  = $clog2(DIV_STEPS);

   state_type          state_ff, state_in;
   logic [ORDER_W-1:0] order_ff;
   logic [IW-1:0]      i_ff, i_in;
   logic [IW-1:0]      j_ff, j_in;
   logic [IW-1:0]      oi_ff, oi_in;
   logic [RAW-1:0]     n_ff, n_in;
   logic [DCW-1:0]     cnt_ff, cnt_in;
   logic               sing_ff, sing_in;
   logic [IW-1:0]      p;

   always_comb begin
      if (order_ff == '0) begin
         p = IW'(1);
      end else if (int'(order_ff) > MAX_ORDER) begin
         p = IW'(MAX_ORDER);
      end else begin
         p = IW'(order_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         order_ff <= ORDER_RESET;
         i_ff     <= '0;
         j_ff     <= '0;
         oi_ff    <= '0;
         n_ff     <= '0;
         cnt_ff   <= '0;
         sing_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            order_ff <= csr_order;
         end
         i_ff    <= i_in;
         j_ff    <= j_in;
         oi_ff   <= oi_in;
         n_ff    <= n_in;
         cnt_ff  <= cnt_in;
         sing_ff <= sing_in;
      end
   end

   logic last_j;
   assign last_j = (j_ff == i_ff - IW'(1));

   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      oi_in     = oi_ff;
      n_in      = n_ff;
      cnt_in    = cnt_ff;
      sing_in   = sing_ff;
      cmd       = '0;
      cmd.mul_sel = MUL_AR;
      cmd.wd_sel  = WD_ZERO;
      cmd.sing    = sing_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      r_raddr   = '0;
      a_raddr   = '0;
      a_waddr   = '0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accum = 1'b1;
               if (req_frame_end) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            oi_in = '0;
            if (status.energy_zero) begin
               sing_in  = 1'b1;
               state_in = ST_O_RD;
            end else begin
               sing_in       = 1'b0;
               cmd.norm_load = 1'b1;
               state_in      = ST_NORM;
            end
         end
         ST_NORM: begin
            if (status.norm_done) begin
               cmd.err_init = 1'b1;
               n_in         = '0;
               state_in     = ST_RWRITE;
            end else begin
               cmd.norm_step = 1'b1;
            end
         end
         ST_RWRITE: begin
            cmd.r_we   = 1'b1;
            cmd.a_we   = (int'(n_ff) < MAX_ORDER);
            cmd.wd_sel = WD_ZERO;
            a_waddr    = AAW'(XW'(n_ff));
            if (int'(n_ff) == MAX_ORDER) begin
               i_in     = IW'(1);
               state_in = ST_ITER;
            end else begin
               n_in = n_ff + RAW'(1);
            end
         end
         ST_ITER: begin
            r_raddr = RAW'(i_ff);
            if ((i_ff > p) || status.err_zero) begin
               oi_in    = '0;
               state_in = ST_O_RD;
            end else begin
               state_in = ST_ACC_INIT;
            end
         end
         ST_ACC_INIT: begin
            cmd.acc_init = 1'b1;
            j_in         = IW'(1);
            state_in     = (i_ff == IW'(1)) ? ST_DIV_START : ST_N_RD;
         end
         ST_N_RD: begin
            a_raddr  = AAW'(XW'(j_ff) - XW'(1));
            r_raddr  = RAW'(XW'(i_ff) - XW'(j_ff));
            state_in = ST_N_MUL;
         end
         ST_N_MUL: begin
            cmd.mul_sel = MUL_AR;
            state_in    = ST_N_PROD;
         end
         ST_N_PROD: begin
            state_in = ST_N_ACC;
         end
         ST_N_ACC: begin
            cmd.acc_sub = 1'b1;
            if (last_j) begin
               state_in = ST_DIV_START;
            end else begin
               j_in     = j_ff + IW'(1);
               state_in = ST_N_RD;
            end
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            cnt_in        = '0;
            state_in      = ST_DIV_STEP;
         end
         ST_DIV_STEP: begin
            cmd.div_step = 1'b1;
            if (int'(cnt_ff) == DIV_STEPS - 1) begin
               state_in = ST_DIV_END;
            end else begin
               cnt_in = cnt_ff + DCW'(1);
            end
         end
         ST_DIV_END: begin
            cmd.k_load = 1'b1;
            j_in       = IW'(1);
            state_in   = (i_ff == IW'(1)) ? ST_K_WR : ST_U_RD;
         end
         ST_U_RD: begin
            a_raddr  = AAW'(XW'(i_ff) - XW'(j_ff) - XW'(1));
            state_in = ST_U_MUL;
         end
         ST_U_MUL: begin
            cmd.mul_sel = MUL_KA;
            a_raddr     = AAW'(XW'(j_ff) - XW'(1));
            state_in    = ST_U_PROD;
         end
         ST_U_PROD: begin
            a_raddr  = AAW'(XW'(j_ff) - XW'(1));
            state_in = ST_U_WR;
         end
         ST_U_WR: begin
            cmd.a_we   = 1'b1;
            cmd.wd_sel = WD_UPD;
            a_waddr    = AAW'(XW'(MAX_ORDER) + XW'(j_ff) - XW'(1));
            if (last_j) begin
               j_in     = IW'(1);
               state_in = ST_C_RD;
            end else begin
               j_in     = j_ff + IW'(1);
               state_in = ST_U_RD;
            end
         end
         ST_C_RD: begin
            a_raddr  = AAW'(XW'(MAX_ORDER) + XW'(j_ff) - XW'(1));
            state_in = ST_C_WR;
         end
         ST_C_WR: begin
            cmd.a_we   = 1'b1;
            cmd.wd_sel = WD_COPY;
            a_waddr    = AAW'(XW'(j_ff) - XW'(1));
            if (last_j) begin
               state_in = ST_K_WR;
            end else begin
               j_in     = j_ff + IW'(1);
               state_in = ST_C_RD;
            end
         end
         ST_K_WR: begin
            cmd.a_we   = 1'b1;
            cmd.wd_sel = WD_K;
            a_waddr    = AAW'(XW'(i_ff) - XW'(1));
            state_in   = ST_E_MUL1;
         end
         ST_E_MUL1: begin
            cmd.mul_sel = MUL_KK;
            state_in    = ST_E_PROD1;
         end
         ST_E_PROD1: begin
            state_in = ST_E_K2;
         end
         ST_E_K2: begin
            cmd.k2_load = 1'b1;
            state_in    = ST_E_MUL2;
         end
         ST_E_MUL2: begin
            cmd.mul_sel = MUL_EK;
            state_in    = ST_E_PROD2;
         end
         ST_E_PROD2: begin
            state_in = ST_E_ERR;
         end
         ST_E_ERR: begin
            cmd.err_upd = 1'b1;
            i_in        = i_ff + IW'(1);
            state_in    = ST_ITER;
         end
         ST_O_RD: begin
            a_raddr  = AAW'(XW'(oi_ff));
            state_in = ST_O_LOAD;
         end
         ST_O_LOAD: begin
            cmd.rsp_load = 1'b1;
            state_in     = ST_O_WAIT;
         end
         ST_O_WAIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (oi_ff == p - IW'(1)) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  oi_in    = oi_ff + IW'(1);
                  state_in = ST_O_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign r_index         = n_ff;
   assign csr_ready       = 1'b1;
   assign rsp_coeff_index = INDEX_W'(oi_ff);
   assign rsp_last_coeff  = (oi_ff == p - IW'(1));
   assign rsp_singular    = sing_ff;

endmodule

// ===== rtl/core/lpc_coefficient_estimator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_coefficient_estimator_core
// Linear prediction coefficients of a pcm frame by the autocorrelation
// method and a fixed-point levinson-durbin solve.
//
// req_*: one signed sample per item, req_frame_end on the last one of a
//   frame. A sample is taken when req_valid meets req_ready; all lag sums update at once.
// rsp_*: after a frame end, order items (clamped to 1..MAX_ORDER), one per
//   coefficient, index 0 first, rsp_last_coeff last, rsp_singular at energy 0.
// csr_*: writes the order register (reset 10), always ready; write it only
//   while no frame is being solved or emitted.
// Solve sequence after the frame end: an energy check, the normalization search,
//   storing the MAX_ORDER+1 scaled lags, then per step i the numerator sum, the
//   serial 25-step divider and the updates on the shared split multiplier, then
//   per coefficient a read, a load and a wait for the receiver.
// No sample is taken while a frame is solved or emitted; a stalled receiver
//   holds the current coefficient and the block waits.
// Reset (synchronous) clears the lag sums and the sequencer and sets the order
//   register to 10; the block is ready for samples in the next cycle.
// ----------------------------------------------------------------------------
module lpc_coefficient_estimator_core #(
   parameter int MAX_ORDER    = 16,
   parameter int MAX_FRAME    = 1024,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]         req_sample,
   input  logic                                   req_frame_end,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [lpcce_pkg::INDEX_W-1:0]          rsp_coeff_index,
   output logic signed [lpcce_pkg::OUT_W-1:0]     rsp_coefficient,
   output logic                                   rsp_last_coeff,
   output logic                                   rsp_singular,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [lpcce_pkg::ORDER_W-1:0]          csr_order
);
   import lpcce_pkg::*;

   localparam int RAW = $clog2(MAX_ORDER + 1);
   localparam int AAW = $clog2(2 * MAX_ORDER);

   cmd_type        cmd;
   status_type     status;
   logic [RAW-1:0] r_index;
   logic [RAW-1:0] r_raddr;
   logic [AAW-1:0] a_raddr;
   logic [AAW-1:0] a_waddr;

   lpcce_ctrl #(.MAX_ORDER(MAX_ORDER)) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_frame_end   (req_frame_end),
      .req_ready       (req_ready),
      .csr_valid       (csr_valid),
      .csr_order       (csr_order),
      .csr_ready       (csr_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_coeff_index (rsp_coeff_index),
      .rsp_last_coeff  (rsp_last_coeff),
      .rsp_singular    (rsp_singular),
      .cmd             (cmd),
      .status          (status),
      .r_index         (r_index),
      .r_raddr         (r_raddr),
      .a_raddr         (a_raddr),
      .a_waddr         (a_waddr)
   );

   lpcce_dpath #(
      .MAX_ORDER    (MAX_ORDER),
      .MAX_FRAME    (MAX_FRAME),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .sample      (req_sample),
      .r_index     (r_index),
      .r_raddr     (r_raddr),
      .a_raddr     (a_raddr),
      .a_waddr     (a_waddr),
      .coefficient (rsp_coefficient)
   );

endmodule
